// File: rtl/core/rgb565_box_downscaler_assert.svh
`ifndef RGB565_BOX_DOWNSCALER_ASSERT_SVH
`define RGB565_BOX_DOWNSCALER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RBD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define RBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/rbd_pkg.sv
package rbd_pkg;

  localparam int DIV_LANES = 3;
  localparam int DIV_DW    = 27;
  localparam int DIV_VW    = 22;
  localparam int DIV_CW    = 5;

  localparam int SUM_R_W = 25;
  localparam int SUM_G_W = 26;
  localparam int SUM_B_W = 25;
  localparam int SUM_W   = SUM_R_W + SUM_G_W + SUM_B_W;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT  = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_ENABLE = 8'd4;

  localparam int TARGET_HEIGHT_LIMIT = 256;
  localparam int BOX_RATIO_X8        = 12;

  typedef struct packed {
    logic                                start;
    logic [DIV_VW-1:0]                   divisor;
    logic [DIV_LANES-1:0][DIV_DW-1:0]    dividend;
  } div_req_t;

  typedef struct packed {
    logic                                busy;
    logic [DIV_LANES-1:0][DIV_DW-1:0]    quot;
    logic [DIV_VW-1:0]                   rem;
  } div_rsp_t;

endpackage

// File: rtl/core/rbd_div.sv
module rbd_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rbd_pkg::div_req_t req_i,
  output rbd_pkg::div_rsp_t rsp_o
);

  logic                                             busy_q;
  logic [rbd_pkg::DIV_CW-1:0]                       cnt_q;
  logic [rbd_pkg::DIV_VW-1:0]                       divisor_q;
  logic [rbd_pkg::DIV_LANES-1:0][rbd_pkg::DIV_DW-1:0] quot_q;
  logic [rbd_pkg::DIV_LANES-1:0][rbd_pkg::DIV_VW-1:0] rem_q;
  logic [rbd_pkg::DIV_LANES-1:0][rbd_pkg::DIV_DW-1:0] quot_d;
  logic [rbd_pkg::DIV_LANES-1:0][rbd_pkg::DIV_VW-1:0] rem_d;

  // One restoring step per lane, all lanes share the divisor.
  always_comb begin
    logic [rbd_pkg::DIV_VW:0] sh;
    for (int l = 0; l < rbd_pkg::DIV_LANES; l++) begin
      sh = {rem_q[l], quot_q[l][rbd_pkg::DIV_DW-1]};
      if (sh >= {1'b0, divisor_q}) begin
        rem_d[l]  = rbd_pkg::DIV_VW'(sh - {1'b0, divisor_q});
        quot_d[l] = {quot_q[l][rbd_pkg::DIV_DW-2:0], 1'b1};
      end else begin
        rem_d[l]  = sh[rbd_pkg::DIV_VW-1:0];
        quot_d[l] = {quot_q[l][rbd_pkg::DIV_DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= rbd_pkg::DIV_CW'(rbd_pkg::DIV_DW - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      divisor_q <= req_i.divisor;
      quot_q    <= req_i.dividend;
      rem_q     <= '0;
    end else if (busy_q) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q[0];

endmodule

// File: rtl/core/rgb565_box_downscaler.sv
// RGB565 box downscaler.
// Source pixels enter on src (valid/ready) in raster order; destination
// pixels leave on dst (valid/ready) in raster order, with frame_last_o set on
// the final pixel of a frame. Geometry is written through cfg (valid/ready,
// always ready) and is sampled on the first source pixel of each frame.
// One source beat is taken at a time. Box mode adds a column-sum
// read-modify-write to each beat. A beat that closes a column box adds one
// 27-step divide; one that closes a row band adds another; a box-mode emit
// adds a third divide for the rounded means. The first beat of a row adds one
// divide for the first column box, and the first beat of a frame adds a second
// one for the first row band. All divides share the one radix-2 divider.
// After reset a clearing pass zeroes the MAX_TARGET_WIDTH-entry column-sum
// memory, one entry per cycle, with src_ready_o low; cfg is taken as ever.
// The destination pixel sits in an output register, so a stalled receiver
// only blocks the source side when a new result is ready and the register is
// still full.
`include "rgb565_box_downscaler_assert.svh"

module rgb565_box_downscaler #(
  parameter int MAX_SOURCE_WIDTH  = 1024,
  parameter int MAX_SOURCE_HEIGHT = 1024,
  parameter int MAX_TARGET_WIDTH  = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             src_valid_i,
  output logic                             src_ready_o,
  input  logic [15:0]                      source_pixel_i,
  output logic                             dst_valid_o,
  input  logic                             dst_ready_i,
  output logic [15:0]                      target_pixel_o,
  output logic                             frame_last_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rbd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rbd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int DEPTH = MAX_TARGET_WIDTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ROW_INIT, S_COL_INIT, S_STEP, S_ACC,
    S_MEAN, S_POST, S_COL_NEXT, S_ROW_ADV, S_ROW_NEXT
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [10:0] cfg_sw_q, cfg_sh_q;
  logic [8:0]  cfg_tw_q, cfg_th_q;
  logic        cfg_avg_q;

  // Per-frame geometry, latched on the first beat of a frame.
  logic [10:0] fr_sw_q, fr_sh_q;
  logic [8:0]  fr_tw_q, fr_th_q;
  logic        fr_valid_q, fr_box_q;

  // Raster and box tracking.
  logic [10:0] col_q, row_q;
  logic [8:0]  crem_q, rrem_q;
  logic [8:0]  tc_q, tr_q;
  logic [10:0] bcs_q, bce_q, brs_q, bre_q;

  logic [15:0] pix_q;
  logic [rbd_pkg::SUM_R_W-1:0] sum_r_q;
  logic [rbd_pkg::SUM_G_W-1:0] sum_g_q;
  logic [rbd_pkg::SUM_B_W-1:0] sum_b_q;
  logic [21:0] area_q;
  logic        last_q;
  logic        div_run_q;
  logic [AW-1:0] clr_addr_q;

  logic        out_valid_q;
  logic [15:0] out_pix_q;
  logic        out_last_q;

  // Column-sum memory: {red, green, blue}.
  logic [rbd_pkg::SUM_W-1:0] sum_mem [DEPTH];
  logic [rbd_pkg::SUM_W-1:0] ram_rdata_q;
  logic [rbd_pkg::SUM_W-1:0] ram_wdata;
  logic [AW-1:0]             ram_waddr;
  logic [AW-1:0]             tc_addr;
  logic                      ram_we, ram_re;

  rbd_pkg::div_req_t div_req;
  rbd_pkg::div_rsp_t div_rsp;

  // Frame geometry derived from the registers.
  logic        cf_valid, cf_box;
  logic [10:0] cf_sw, cf_sh;
  logic [8:0]  cf_tw, cf_th;

  logic        active, last, out_free, div_done;
  logic [11:0] col_inc, row_inc;
  logic        acc_emit;
  logic [rbd_pkg::SUM_R_W-1:0] nsum_r;
  logic [rbd_pkg::SUM_G_W-1:0] nsum_g;
  logic [rbd_pkg::SUM_B_W-1:0] nsum_b;
  logic [21:0] area_n;
  logic [10:0] box_w, band_h;

  always_comb begin
    cf_valid = (cfg_tw_q != '0) && (cfg_th_q != '0) &&
               ({2'b00, cfg_tw_q} <= cfg_sw_q) && ({2'b00, cfg_th_q} <= cfg_sh_q) &&
               (32'(cfg_sw_q) <= MAX_SOURCE_WIDTH) &&
               (32'(cfg_sh_q) <= MAX_SOURCE_HEIGHT) &&
               (32'(cfg_tw_q) <= MAX_TARGET_WIDTH) &&
               (32'(cfg_th_q) <= rbd_pkg::TARGET_HEIGHT_LIMIT);
    // Clamp so the raster counters always wrap, even in a swallowed frame.
    if (cfg_sw_q == '0) begin
      cf_sw = 11'd1;
    end else if (32'(cfg_sw_q) > MAX_SOURCE_WIDTH) begin
      cf_sw = 11'(MAX_SOURCE_WIDTH);
    end else begin
      cf_sw = cfg_sw_q;
    end
    if (cfg_sh_q == '0) begin
      cf_sh = 11'd1;
    end else if (32'(cfg_sh_q) > MAX_SOURCE_HEIGHT) begin
      cf_sh = 11'(MAX_SOURCE_HEIGHT);
    end else begin
      cf_sh = cfg_sh_q;
    end
    cf_tw  = cf_valid ? cfg_tw_q : 9'd1;
    cf_th  = cf_valid ? cfg_th_q : 9'd1;
    // Box mode only when the shrink is at least 1.5 in both axes.
    cf_box = cf_valid && cfg_avg_q &&
             ({1'b0, cf_sw, 3'b000} >= 15'(cf_tw) * 15'(rbd_pkg::BOX_RATIO_X8)) &&
             ({1'b0, cf_sh, 3'b000} >= 15'(cf_th) * 15'(rbd_pkg::BOX_RATIO_X8));
  end

  assign tc_addr  = AW'(tc_q);
  assign active   = fr_valid_q && (32'(tc_q) < MAX_TARGET_WIDTH);
  assign last     = (tr_q == fr_th_q - 9'd1) && (tc_q == fr_tw_q - 9'd1);
  assign out_free = !out_valid_q || dst_ready_i;
  assign div_done = div_run_q && !div_rsp.busy;
  assign col_inc  = {1'b0, col_q} + 12'd1;
  assign row_inc  = {1'b0, row_q} + 12'd1;
  assign acc_emit = (col_inc == {1'b0, bce_q}) && (row_inc == {1'b0, bre_q});

  // Accumulate this beat's channels onto the column sums just read.
  assign nsum_r = ram_rdata_q[rbd_pkg::SUM_W-1 -: rbd_pkg::SUM_R_W] +
                  rbd_pkg::SUM_R_W'(pix_q[15:11]);
  assign nsum_g = ram_rdata_q[rbd_pkg::SUM_B_W +: rbd_pkg::SUM_G_W] +
                  rbd_pkg::SUM_G_W'(pix_q[10:5]);
  assign nsum_b = ram_rdata_q[rbd_pkg::SUM_B_W-1:0] + rbd_pkg::SUM_B_W'(pix_q[4:0]);

  assign box_w  = bce_q - bcs_q;
  assign band_h = bre_q - brs_q;
  assign area_n = (area_q == '0) ? 22'd1 : area_q;

  // Memory port control.
  always_comb begin
    ram_re    = (state_q == S_STEP) && active && fr_box_q;
    ram_we    = 1'b0;
    ram_waddr = tc_addr;
    ram_wdata = '0;
    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
      end
      S_ACC: begin
        ram_we    = 1'b1;
        ram_wdata = acc_emit ? '0 : {nsum_r, nsum_g, nsum_b};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      sum_mem[ram_waddr] <= ram_wdata;
    end
    if (ram_re) begin
      ram_rdata_q <= sum_mem[tc_addr];
    end
  end

  // Divider operands per state.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.divisor  = rbd_pkg::DIV_VW'(1);
    div_req.dividend = '0;
    case (state_q)
      S_ROW_INIT: begin
        div_req.start       = !div_run_q;
        div_req.divisor     = rbd_pkg::DIV_VW'(fr_th_q);
        div_req.dividend[0] = rbd_pkg::DIV_DW'(fr_sh_q);
      end
      S_COL_INIT: begin
        div_req.start       = !div_run_q;
        div_req.divisor     = rbd_pkg::DIV_VW'(fr_tw_q);
        div_req.dividend[0] = rbd_pkg::DIV_DW'(fr_sw_q);
      end
      S_COL_NEXT: begin
        div_req.start       = !div_run_q;
        div_req.divisor     = rbd_pkg::DIV_VW'(fr_tw_q);
        div_req.dividend[0] = rbd_pkg::DIV_DW'(crem_q) + rbd_pkg::DIV_DW'(fr_sw_q);
      end
      S_ROW_NEXT: begin
        div_req.start       = !div_run_q;
        div_req.divisor     = rbd_pkg::DIV_VW'(fr_th_q);
        div_req.dividend[0] = rbd_pkg::DIV_DW'(rrem_q) + rbd_pkg::DIV_DW'(fr_sh_q);
      end
      S_MEAN: begin
        // Rounded mean: (sum + n/2) / n.
        div_req.start       = !div_run_q;
        div_req.divisor     = area_n;
        div_req.dividend[0] = rbd_pkg::DIV_DW'(sum_r_q) + rbd_pkg::DIV_DW'(area_n >> 1);
        div_req.dividend[1] = rbd_pkg::DIV_DW'(sum_g_q) + rbd_pkg::DIV_DW'(area_n >> 1);
        div_req.dividend[2] = rbd_pkg::DIV_DW'(sum_b_q) + rbd_pkg::DIV_DW'(area_n >> 1);
      end
      default: ;
    endcase
  end

  rbd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Configuration writes; codes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_sw_q  <= 11'd120;
      cfg_sh_q  <= 11'd120;
      cfg_tw_q  <= 9'd56;
      cfg_th_q  <= 9'd56;
      cfg_avg_q <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rbd_pkg::CFG_SOURCE_WIDTH:   cfg_sw_q  <= cfg_data_i;
        rbd_pkg::CFG_SOURCE_HEIGHT:  cfg_sh_q  <= cfg_data_i;
        rbd_pkg::CFG_TARGET_WIDTH:   cfg_tw_q  <= cfg_data_i[8:0];
        rbd_pkg::CFG_TARGET_HEIGHT:  cfg_th_q  <= cfg_data_i[8:0];
        rbd_pkg::CFG_AVERAGE_ENABLE: cfg_avg_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sequencer: state and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      fr_sw_q     <= 11'd1;
      fr_sh_q     <= 11'd1;
      fr_tw_q     <= 9'd1;
      fr_th_q     <= 9'd1;
      fr_valid_q  <= 1'b0;
      fr_box_q    <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      crem_q      <= '0;
      rrem_q      <= '0;
      tc_q        <= '0;
      tr_q        <= '0;
      bcs_q       <= '0;
      bce_q       <= '0;
      brs_q       <= '0;
      bre_q       <= '0;
      div_run_q   <= 1'b0;
      out_valid_q <= 1'b0;
      pix_q       <= '0;
      sum_r_q     <= '0;
      sum_g_q     <= '0;
      sum_b_q     <= '0;
      area_q      <= '0;
      last_q      <= 1'b0;
      out_pix_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_valid_q && dst_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (div_req.start) begin
        div_run_q <= 1'b1;
      end
      case (state_q)
        S_CLEAR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_addr_q == AW'(DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (src_valid_i) begin
            pix_q <= source_pixel_i;
            if (col_q == '0) begin
              if (row_q == '0) begin
                fr_sw_q    <= cf_sw;
                fr_sh_q    <= cf_sh;
                fr_tw_q    <= cf_tw;
                fr_th_q    <= cf_th;
                fr_valid_q <= cf_valid;
                fr_box_q   <= cf_box;
                tr_q       <= '0;
                brs_q      <= '0;
                state_q    <= S_ROW_INIT;
              end else begin
                state_q <= S_COL_INIT;
              end
            end else begin
              state_q <= S_STEP;
            end
          end
        end
        S_ROW_INIT: begin
          if (div_done) begin
            div_run_q <= 1'b0;
            bre_q     <= 11'(div_rsp.quot[0]);
            rrem_q    <= 9'(div_rsp.rem);
            state_q   <= S_COL_INIT;
          end
        end
        S_COL_INIT: begin
          if (div_done) begin
            div_run_q <= 1'b0;
            tc_q      <= '0;
            bcs_q     <= '0;
            bce_q     <= 11'(div_rsp.quot[0]);
            crem_q    <= 9'(div_rsp.rem);
            state_q   <= S_STEP;
          end
        end
        S_STEP: begin
          if (active && fr_box_q) begin
            state_q <= S_ACC;
          end else if (active && (col_q == bcs_q) && (row_q == brs_q)) begin
            // Nearest neighbour: emit the top-left pixel of the box.
            if (out_free) begin
              out_valid_q <= 1'b1;
              out_pix_q   <= pix_q;
              out_last_q  <= last;
              state_q     <= S_POST;
            end
          end else begin
            state_q <= S_POST;
          end
        end
        S_ACC: begin
          if (acc_emit) begin
            sum_r_q <= nsum_r;
            sum_g_q <= nsum_g;
            sum_b_q <= nsum_b;
            area_q  <= 22'(box_w) * 22'(band_h);
            last_q  <= last;
            state_q <= S_MEAN;
          end else begin
            state_q <= S_POST;
          end
        end
        S_MEAN: begin
          if (div_done && out_free) begin
            div_run_q   <= 1'b0;
            out_valid_q <= 1'b1;
            out_pix_q   <= {div_rsp.quot[0][4:0], div_rsp.quot[1][5:0],
                            div_rsp.quot[2][4:0]};
            out_last_q  <= last_q;
            state_q     <= S_POST;
          end
        end
        S_POST: begin
          if (fr_valid_q && (col_inc == {1'b0, bce_q})) begin
            tc_q    <= tc_q + 9'd1;
            state_q <= S_COL_NEXT;
          end else begin
            state_q <= S_ROW_ADV;
          end
        end
        S_COL_NEXT: begin
          if (div_done) begin
            div_run_q <= 1'b0;
            bcs_q     <= bce_q;
            bce_q     <= bce_q + 11'(div_rsp.quot[0]);
            crem_q    <= 9'(div_rsp.rem);
            state_q   <= S_ROW_ADV;
          end
        end
        S_ROW_ADV: begin
          if (col_inc >= {1'b0, fr_sw_q}) begin
            col_q <= '0;
            row_q <= (row_inc >= {1'b0, fr_sh_q}) ? 11'd0 : row_inc[10:0];
            if (fr_valid_q && (row_inc == {1'b0, bre_q})) begin
              tr_q    <= tr_q + 9'd1;
              state_q <= S_ROW_NEXT;
            end else begin
              state_q <= S_IDLE;
            end
          end else begin
            col_q   <= col_inc[10:0];
            state_q <= S_IDLE;
          end
        end
        S_ROW_NEXT: begin
          if (div_done) begin
            div_run_q <= 1'b0;
            brs_q     <= bre_q;
            bre_q     <= bre_q + 11'(div_rsp.quot[0]);
            rrem_q    <= 9'(div_rsp.rem);
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign src_ready_o    = (state_q == S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign dst_valid_o    = out_valid_q;
  assign target_pixel_o = out_pix_q;
  assign frame_last_o   = out_last_q;

  `RBD_ASSERT_IMPL(a_clear_blocks_src, state_q == S_CLEAR, !src_ready_o, "beat taken during clear")
  `RBD_ASSERT_IMPL(a_div_start_free, div_req.start, !div_rsp.busy, "divider started while busy")
  `RBD_ASSERT_NEXT(a_div_runs, div_req.start, div_rsp.busy, "divider did not start")
  `RBD_ASSERT_IMPL(a_col_in_frame, state_q == S_STEP, col_q < fr_sw_q, "column beyond frame width")

endmodule
